// ===== hdl/tild_pkg.sv =====
// ----------------------------------------------------------------------------
// tild_pkg
// Shared types, constants and helper functions of the terminal input line
// discipline.
// ----------------------------------------------------------------------------
`default_nettype none

package tild_pkg;

  // Ring geometry. The ring holds at most BUF_DEPTH-1 bytes.
  localparam int BUF_DEPTH = 1024;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int LINES_W   = 16;
  localparam int RUB_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Character constants.
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CTL_OFFSET  = 8'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_FLAGS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_FLAGS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CC_A        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CC_B        = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [4:0]  RST_INPUT_FLAGS = 5'd17;
  localparam logic [3:0]  RST_LOCAL_FLAGS = 4'd15;
  localparam logic [31:0] RST_CC_A        = 32'h157F_1C03;
  localparam logic [31:0] RST_CC_B        = 32'h1A13_1104;

  // Bit positions inside input_flags.
  localparam int IF_CRNL  = 0;
  localparam int IF_IGNCR = 1;
  localparam int IF_NLCR  = 2;
  localparam int IF_FOLD  = 3;
  localparam int IF_XON   = 4;

  // Bit positions inside local_flags.
  localparam int LF_CANON = 0;
  localparam int LF_SIG   = 1;
  localparam int LF_ECHO  = 2;
  localparam int LF_ECHOC = 3;

  // Byte slots inside the control character registers.
  localparam int CCA_INTR  = 0;
  localparam int CCA_QUIT  = 1;
  localparam int CCA_ERASE = 2;
  localparam int CCA_KILL  = 3;
  localparam int CCB_EOF   = 0;
  localparam int CCB_START = 1;
  localparam int CCB_STOP  = 2;
  localparam int CCB_SUSP  = 3;

  // Request codes.
  localparam logic REQ_RECV = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // Signal codes.
  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;
  localparam logic [1:0] SIG_SUSP = 2'd3;

  typedef struct packed {
    logic [4:0]  input_flags;
    logic [3:0]  local_flags;
    logic [31:0] cc_a;
    logic [31:0] cc_b;
  } cfg_t;

  typedef struct packed {
    logic             accepted;
    logic [7:0]       read_char;
    logic [1:0]       echo_count;
    logic [7:0]       echo_first;
    logic [7:0]       echo_second;
    logic [RUB_W-1:0] rubout_count;
    logic [1:0]       signal_code;
    logic             output_stopped;
    logic             write_kick;
    logic [9:0]       line_count;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(BUF_DEPTH - 1) : p - 1'b1;
  endfunction

  // A control character slot of zero never matches.
  function automatic logic cc_match(input logic [31:0] cc, input int n,
                                    input logic [7:0] c);
    logic [7:0] k;
    k = cc[8*n +: 8];
    return (k != 8'd0) && (k == c);
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    return (c < CH_SPACE) || c[7];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tild_ring_ram.sv =====
// ----------------------------------------------------------------------------
// tild_ring_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tild_ring_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tild_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tild_cfg_regs
// Configuration register file: flags and control characters.
// ----------------------------------------------------------------------------
`default_nettype none

module tild_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tild_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output tild_pkg::cfg_t                      cfg
);

  tild_pkg::cfg_t cfg_r;
  tild_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tild_pkg::REG_INPUT_FLAGS: cfg_nxt.input_flags = cfg_data[4:0];
        tild_pkg::REG_LOCAL_FLAGS: cfg_nxt.local_flags = cfg_data[3:0];
        tild_pkg::REG_CC_A:        cfg_nxt.cc_a        = cfg_data;
        tild_pkg::REG_CC_B:        cfg_nxt.cc_b        = cfg_data;
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_flags <= tild_pkg::RST_INPUT_FLAGS;
      cfg_r.local_flags <= tild_pkg::RST_LOCAL_FLAGS;
      cfg_r.cc_a        <= tild_pkg::RST_CC_A;
      cfg_r.cc_b        <= tild_pkg::RST_CC_B;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tild_engine.sv =====
// ----------------------------------------------------------------------------
// tild_engine
// Sequencer of the line discipline: translates a received byte, decides its
// fate, and reads, stores or removes ring bytes through the ring RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module tild_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tild_pkg::cfg_t             cfg,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       req_type,
  input  wire logic [7:0]                 in_char,
  output logic                            ram_we,
  output logic [tild_pkg::PTR_W-1:0]      ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic [tild_pkg::PTR_W-1:0]      ram_raddr,
  input  wire logic [7:0]                 ram_rdata,
  output logic                            res_valid,
  output tild_pkg::res_t                  res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_KILL = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic [tild_pkg::PTR_W-1:0]        wp_r, wp_nxt;
  logic [tild_pkg::PTR_W-1:0]        rp_r, rp_nxt;
  logic [tild_pkg::LINES_W-1:0]      lines_r, lines_nxt;
  logic                              stop_r, stop_nxt;
  logic                              req_r, req_nxt;
  logic [7:0]                        c_r, c_nxt;
  logic                              ign_r, ign_nxt;
  logic                              single_r, single_nxt;
  logic [tild_pkg::RUB_W-1:0]        rub_r, rub_nxt;
  logic                              kick_r, kick_nxt;
  logic                              valid_r;
  tild_pkg::res_t                    res_r, res_nxt;
  logic                              fin;

  logic                              echo;
  logic                              empty;
  logic                              full;
  logic                              blocked;
  logic [7:0]                        xlat;
  logic                              xlat_ign;
  logic [tild_pkg::RUB_W:0]          rub_sum;

  assign echo    = cfg.local_flags[tild_pkg::LF_ECHO];
  assign empty   = (wp_r == rp_r);
  assign full    = (tild_pkg::ptr_inc(wp_r) == rp_r);
  // The last stored byte is in ram_rdata here; a line end stops erase and kill.
  assign blocked = empty || (ram_rdata == tild_pkg::CH_NL) ||
                   tild_pkg::cc_match(cfg.cc_b, tild_pkg::CCB_EOF, ram_rdata);
  assign rub_sum = {1'b0, rub_r} +
                   (tild_pkg::is_ctl(ram_rdata) ? (tild_pkg::RUB_W+1)'(2)
                                                : (tild_pkg::RUB_W+1)'(1));

  // Input translation of the raw byte, done as the beat is taken.
  always_comb begin
    xlat     = in_char;
    xlat_ign = 1'b0;
    if (in_char == tild_pkg::CH_CR) begin
      if (cfg.input_flags[tild_pkg::IF_CRNL]) begin
        xlat = tild_pkg::CH_NL;
      end else if (cfg.input_flags[tild_pkg::IF_IGNCR]) begin
        xlat_ign = 1'b1;
      end
    end else if (in_char == tild_pkg::CH_NL && cfg.input_flags[tild_pkg::IF_NLCR]) begin
      xlat = tild_pkg::CH_CR;
    end
    if (cfg.input_flags[tild_pkg::IF_FOLD] &&
        xlat >= tild_pkg::CH_UPPER_A && xlat <= tild_pkg::CH_UPPER_Z) begin
      xlat = xlat + tild_pkg::CASE_OFFSET;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    lines_nxt  = lines_r;
    stop_nxt   = stop_r;
    req_nxt    = req_r;
    c_nxt      = c_r;
    ign_nxt    = ign_r;
    single_nxt = single_r;
    rub_nxt    = rub_r;
    kick_nxt   = kick_r;
    fin        = 1'b0;
    res_nxt    = '0;
    ram_we     = 1'b0;
    ram_waddr  = wp_r;
    ram_wdata  = c_r;
    ram_raddr  = tild_pkg::ptr_dec(wp_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = req_type;
          c_nxt     = xlat;
          ign_nxt   = xlat_ign;
          rub_nxt   = '0;
          kick_nxt  = 1'b0;
          ram_raddr = (req_type == tild_pkg::REQ_TAKE) ? rp_r : tild_pkg::ptr_dec(wp_r);
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        state_nxt = S_IDLE;
        fin       = 1'b1;
        if (req_r == tild_pkg::REQ_TAKE) begin
          if (!empty) begin
            res_nxt.accepted  = 1'b1;
            res_nxt.read_char = ram_rdata;
            rp_nxt            = tild_pkg::ptr_inc(rp_r);
            if ((ram_rdata == tild_pkg::CH_NL ||
                 tild_pkg::cc_match(cfg.cc_b, tild_pkg::CCB_EOF, ram_rdata)) &&
                lines_r != '0) begin
              lines_nxt = lines_r - 1'b1;
            end
          end
        end else if (!full) begin
          res_nxt.accepted = 1'b1;
          if (ign_r) begin
            // Ignored carriage return: consumed, nothing else.
          end else if (cfg.local_flags[tild_pkg::LF_CANON] &&
                       tild_pkg::cc_match(cfg.cc_a, tild_pkg::CCA_KILL, c_r)) begin
            single_nxt = 1'b0;
            fin        = 1'b0;
            state_nxt  = S_KILL;
          end else if (cfg.local_flags[tild_pkg::LF_CANON] &&
                       tild_pkg::cc_match(cfg.cc_a, tild_pkg::CCA_ERASE, c_r)) begin
            single_nxt = 1'b1;
            fin        = 1'b0;
            state_nxt  = S_KILL;
          end else if (cfg.input_flags[tild_pkg::IF_XON] &&
                       tild_pkg::cc_match(cfg.cc_b, tild_pkg::CCB_STOP, c_r)) begin
            stop_nxt = 1'b1;
            kick_nxt = 1'b1;
          end else if (cfg.input_flags[tild_pkg::IF_XON] &&
                       tild_pkg::cc_match(cfg.cc_b, tild_pkg::CCB_START, c_r)) begin
            stop_nxt = 1'b0;
            kick_nxt = 1'b1;
          end else if (cfg.local_flags[tild_pkg::LF_SIG] &&
                       tild_pkg::cc_match(cfg.cc_a, tild_pkg::CCA_INTR, c_r)) begin
            res_nxt.signal_code = tild_pkg::SIG_INTR;
          end else if (cfg.local_flags[tild_pkg::LF_SIG] &&
                       tild_pkg::cc_match(cfg.cc_a, tild_pkg::CCA_QUIT, c_r)) begin
            res_nxt.signal_code = tild_pkg::SIG_QUIT;
          end else if (cfg.local_flags[tild_pkg::LF_SIG] &&
                       tild_pkg::cc_match(cfg.cc_b, tild_pkg::CCB_SUSP, c_r)) begin
            res_nxt.signal_code = tild_pkg::SIG_SUSP;
          end else begin
            ram_we = 1'b1;
            wp_nxt = tild_pkg::ptr_inc(wp_r);
            if (c_r == tild_pkg::CH_NL ||
                tild_pkg::cc_match(cfg.cc_b, tild_pkg::CCB_EOF, c_r)) begin
              lines_nxt = lines_r + 1'b1;
            end
            if (echo) begin
              kick_nxt = 1'b1;
              if (c_r == tild_pkg::CH_NL) begin
                res_nxt.echo_count  = 2'd2;
                res_nxt.echo_first  = tild_pkg::CH_NL;
                res_nxt.echo_second = tild_pkg::CH_CR;
              end else if (tild_pkg::is_ctl(c_r)) begin
                if (cfg.local_flags[tild_pkg::LF_ECHOC]) begin
                  res_nxt.echo_count  = 2'd2;
                  res_nxt.echo_first  = tild_pkg::CH_CARET;
                  res_nxt.echo_second = c_r + tild_pkg::CTL_OFFSET;
                end
              end else begin
                res_nxt.echo_count = 2'd1;
                res_nxt.echo_first = c_r;
              end
            end
          end
        end
      end

      S_KILL: begin
        res_nxt.accepted = 1'b1;
        if (blocked) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (echo) begin
            rub_nxt  = rub_sum[tild_pkg::RUB_W] ? '1 : rub_sum[tild_pkg::RUB_W-1:0];
            kick_nxt = 1'b1;
          end
          wp_nxt    = tild_pkg::ptr_dec(wp_r);
          // Fetch the byte before the one just removed for the next step.
          ram_raddr = tild_pkg::ptr_dec(wp_nxt);
          if (single_r) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_nxt.rubout_count   = rub_nxt;
    res_nxt.write_kick     = kick_nxt;
    res_nxt.output_stopped = stop_nxt;
    res_nxt.line_count     = lines_nxt[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      lines_r <= '0;
      stop_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      lines_r <= lines_nxt;
      stop_r  <= stop_nxt;
      valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    c_r      <= c_nxt;
    ign_r    <= ign_nxt;
    single_r <= single_nxt;
    rub_r    <= rub_nxt;
    kick_r   <= kick_nxt;
    if (fin) begin
      res_r <= res_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== hdl/tty_input_line_discipline.sv =====
// ----------------------------------------------------------------------------
// tty_input_line_discipline
// Terminal input line discipline: cooks received bytes into a line ring,
// handles erase, kill, flow control and signal characters, and pops cooked
// bytes on request.
//
//   channel   ports                                 flow
//   input     start, busy, in_req_type, in_char     beat when start && !busy
//   result    out_valid, out_*                      one-cycle strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_index,      beat when valid && ready
//             cfg_data
//
// A plain receive or take keeps busy high through the evaluate state; its
// result strobes in the cycle after, when the next beat may already be taken.
// An erase adds a pass through the kill state; a kill stays in the kill state
// for each removed byte and for a final check, since each step waits on the
// registered read of the ring RAM for the preceding byte.
// Reset is synchronous and clears pointers, line count and stop flag; the
// ring contents are not cleared.
// Results are never held off; out_valid lasts exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tty_input_line_discipline (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_req_type,
  input  wire logic [7:0]                     in_char,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic [7:0]                          out_read_char,
  output logic [1:0]                          out_echo_count,
  output logic [7:0]                          out_echo_first,
  output logic [7:0]                          out_echo_second,
  output logic [10:0]                         out_rubout_count,
  output logic [1:0]                          out_signal_code,
  output logic                                out_output_stopped,
  output logic                                out_write_kick,
  output logic [9:0]                          out_line_count,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tild_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  tild_pkg::cfg_t                 cfg;
  tild_pkg::res_t                 res;
  logic                           ram_we;
  logic [tild_pkg::PTR_W-1:0]     ram_waddr;
  logic [7:0]                     ram_wdata;
  logic [tild_pkg::PTR_W-1:0]     ram_raddr;
  logic [7:0]                     ram_rdata;

  tild_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tild_ring_ram #(
    .DEPTH (tild_pkg::BUF_DEPTH),
    .WIDTH (8)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tild_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .busy      (busy),
    .req_type  (in_req_type),
    .in_char   (in_char),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_accepted       = res.accepted;
  assign out_read_char      = res.read_char;
  assign out_echo_count     = res.echo_count;
  assign out_echo_first     = res.echo_first;
  assign out_echo_second    = res.echo_second;
  assign out_rubout_count   = res.rubout_count;
  assign out_signal_code    = res.signal_code;
  assign out_output_stopped = res.output_stopped;
  assign out_write_kick     = res.write_kick;
  assign out_line_count     = res.line_count;

  // A result always closes a busy period.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A taken beat starts work in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  // A popped byte never comes with echo, rubout or signal output.
  a_take_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_char != 8'd0) |->
      (out_echo_count == 2'd0 && out_rubout_count == '0 &&
       out_signal_code == tild_pkg::SIG_NONE && !out_write_kick))
    else $error("take result carries receive-side output");

  // At most two echo bytes exist.
  a_echo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_echo_count != 2'd3))
    else $error("echo count out of range");

endmodule

`default_nettype wire

// ===== tb/tty_input_line_discipline_tb.sv =====
// ----------------------------------------------------------------------------
// tty_input_line_discipline_tb
// Self-checking bench for the terminal input line discipline. A keystroke
// queue feeds a bursty command driver; a shadow line discipline predicts the
// result of every accepted beat, and a monitor compares each result strobe
// field by field. Phases change the flags and control characters while the
// block is idle, fill the ring to the point where receives are refused, and
// walk long line kills.
// ----------------------------------------------------------------------------
module tty_input_line_discipline_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tild_pkg::*;

  typedef struct {
    logic       req;
    logic [7:0] ch;
    bit         hold;
  } keystroke_t;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic                 in_req_type = REQ_RECV;
  logic [7:0]           in_char     = 8'd0;
  logic                 out_valid;
  logic                 out_accepted;
  logic [7:0]           out_read_char;
  logic [1:0]           out_echo_count;
  logic [7:0]           out_echo_first;
  logic [7:0]           out_echo_second;
  logic [10:0]          out_rubout_count;
  logic [1:0]           out_signal_code;
  logic                 out_output_stopped;
  logic                 out_write_kick;
  logic [9:0]           out_line_count;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_INPUT_FLAGS;
  logic [31:0]          cfg_data    = 32'd0;

  // Shadow copy of the line discipline state and its registers.
  logic [7:0]  shadow_ring [BUF_DEPTH];
  int unsigned wr_ptr     = 0;
  int unsigned rd_ptr     = 0;
  int unsigned held_lines = 0;
  bit          xoff_state = 1'b0;
  logic [4:0]  cfg_iflags = RST_INPUT_FLAGS;
  logic [3:0]  cfg_lflags = RST_LOCAL_FLAGS;
  logic [31:0] cfg_cca    = RST_CC_A;
  logic [31:0] cfg_ccb    = RST_CC_B;

  keystroke_t keystroke_q [$];
  res_t       awaited_res [$];
  int         mismatches = 0;
  int         stim_count = 0;
  bit         pause_next = 1'b0;
  int         gap_left   = 0;
  int         burst_left = 1;

  tty_input_line_discipline i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_char            (in_char),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_read_char      (out_read_char),
    .out_echo_count     (out_echo_count),
    .out_echo_first     (out_echo_first),
    .out_echo_second    (out_echo_second),
    .out_rubout_count   (out_rubout_count),
    .out_signal_code    (out_signal_code),
    .out_output_stopped (out_output_stopped),
    .out_write_kick     (out_write_kick),
    .out_line_count     (out_line_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] slot_char(logic [31:0] regv, int slot);
    return regv[8*slot +: 8];
  endfunction

  function automatic bit slot_hit(logic [31:0] regv, int slot, logic [7:0] c);
    return slot_char(regv, slot) != 8'd0 && slot_char(regv, slot) == c;
  endfunction

  function automatic bit ctl_char(logic [7:0] c);
    return c < CH_SPACE || c[7];
  endfunction

  function automatic bit ends_line(logic [7:0] c);
    return c == CH_NL || slot_hit(cfg_ccb, CCB_EOF, c);
  endfunction

  function automatic int unsigned prev_pos(int unsigned p);
    return (p + BUF_DEPTH - 1) % BUF_DEPTH;
  endfunction

  function automatic bit nothing_to_erase();
    return wr_ptr == rd_ptr || ends_line(shadow_ring[prev_pos(wr_ptr)]);
  endfunction

  // Applies one receive or take to the shadow state and returns its result.
  function automatic res_t ldisc_step(logic req, logic [7:0] raw);
    res_t        r;
    logic [7:0]  c;
    bit          done;
    bit          echo_on;
    int unsigned rub;
    r       = '0;
    c       = raw;
    done    = 1'b0;
    rub     = 0;
    echo_on = cfg_lflags[LF_ECHO];
    if (req == REQ_TAKE) begin
      if (wr_ptr != rd_ptr) begin
        r.accepted  = 1'b1;
        r.read_char = shadow_ring[rd_ptr];
        rd_ptr      = (rd_ptr + 1) % BUF_DEPTH;
        if (ends_line(r.read_char) && held_lines > 0) held_lines--;
      end
    end else if ((wr_ptr + 1) % BUF_DEPTH != rd_ptr) begin
      r.accepted = 1'b1;
      if (c == CH_CR) begin
        if (cfg_iflags[IF_CRNL]) c = CH_NL;
        else if (cfg_iflags[IF_IGNCR]) done = 1'b1;
      end else if (c == CH_NL && cfg_iflags[IF_NLCR]) begin
        c = CH_CR;
      end
      if (!done && cfg_iflags[IF_FOLD] && c >= CH_UPPER_A && c <= CH_UPPER_Z)
        c += CASE_OFFSET;
      if (!done && cfg_lflags[LF_CANON]) begin
        if (slot_hit(cfg_cca, CCA_KILL, c)) begin
          // The kill stops at the last line end; control bytes take two rubouts.
          done = 1'b1;
          while (!nothing_to_erase()) begin
            if (echo_on) begin
              rub += ctl_char(shadow_ring[prev_pos(wr_ptr)]) ? 2 : 1;
              if (rub > (1 << RUB_W) - 1) rub = (1 << RUB_W) - 1;
              r.write_kick = 1'b1;
            end
            wr_ptr = prev_pos(wr_ptr);
          end
        end else if (slot_hit(cfg_cca, CCA_ERASE, c)) begin
          done = 1'b1;
          if (!nothing_to_erase()) begin
            if (echo_on) begin
              rub          = ctl_char(shadow_ring[prev_pos(wr_ptr)]) ? 2 : 1;
              r.write_kick = 1'b1;
            end
            wr_ptr = prev_pos(wr_ptr);
          end
        end
      end
      if (!done && cfg_iflags[IF_XON]) begin
        if (slot_hit(cfg_ccb, CCB_STOP, c)) begin
          xoff_state   = 1'b1;
          r.write_kick = 1'b1;
          done         = 1'b1;
        end else if (slot_hit(cfg_ccb, CCB_START, c)) begin
          xoff_state   = 1'b0;
          r.write_kick = 1'b1;
          done         = 1'b1;
        end
      end
      if (!done && cfg_lflags[LF_SIG]) begin
        if (slot_hit(cfg_cca, CCA_INTR, c)) begin
          r.signal_code = SIG_INTR;
          done          = 1'b1;
        end else if (slot_hit(cfg_cca, CCA_QUIT, c)) begin
          r.signal_code = SIG_QUIT;
          done          = 1'b1;
        end else if (slot_hit(cfg_ccb, CCB_SUSP, c)) begin
          r.signal_code = SIG_SUSP;
          done          = 1'b1;
        end
      end
      if (!done) begin
        if (ends_line(c)) held_lines = (held_lines + 1) & 32'hFFFF;
        shadow_ring[wr_ptr] = c;
        wr_ptr              = (wr_ptr + 1) % BUF_DEPTH;
        if (echo_on) begin
          r.write_kick = 1'b1;
          if (c == CH_NL) begin
            r.echo_count  = 2'd2;
            r.echo_first  = CH_NL;
            r.echo_second = CH_CR;
          end else if (ctl_char(c)) begin
            if (cfg_lflags[LF_ECHOC]) begin
              r.echo_count  = 2'd2;
              r.echo_first  = CH_CARET;
              r.echo_second = c + CTL_OFFSET;
            end
          end else begin
            r.echo_count = 2'd1;
            r.echo_first = c;
          end
        end
      end
      r.rubout_count = rub[RUB_W-1:0];
    end
    r.output_stopped = xoff_state;
    r.line_count     = held_lines[9:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v,
                                      logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic void push_key(logic req, logic [7:0] ch);
    keystroke_t k;
    k.req      = req;
    k.ch       = ch;
    k.hold     = pause_next || ($urandom_range(0, 99) == 0);
    pause_next = 1'b0;
    keystroke_q.push_back(k);
    stim_count++;
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 11))
      0:       return slot_char(cfg_cca, CCA_ERASE);
      1:       return slot_char(cfg_cca, CCA_KILL);
      2:       return slot_char(cfg_cca, CCA_INTR);
      3:       return slot_char(cfg_cca, CCA_QUIT);
      4:       return slot_char(cfg_ccb, CCB_EOF);
      5:       return slot_char(cfg_ccb, CCB_START);
      6:       return slot_char(cfg_ccb, CCB_STOP);
      7:       return slot_char(cfg_ccb, CCB_SUSP);
      8:       return CH_CR;
      9:       return CH_NL;
      10:      return 8'($urandom_range(0, 31));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_cc();
    logic [31:0] v;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0:       v[8*i +: 8] = 8'd0;
        1:       v[8*i +: 8] = 8'($urandom);
        default: v[8*i +: 8] = 8'($urandom_range(1, 31));
      endcase
    end
    return v;
  endfunction

  // Mostly whole lines with random content, mixed with takes and noise.
  function automatic void gen_random(int n);
    int stop_at;
    int pause_at;
    int len;
    stop_at  = stim_count + n;
    pause_at = stim_count + n / 2;
    while (stim_count < stop_at) begin
      if (pause_at >= 0 && stim_count >= pause_at) begin
        pause_next = 1'b1;
        pause_at   = -1;
      end
      case ($urandom_range(0, 9))
        0: push_key(1'($urandom), 8'($urandom));
        1, 2, 3, 4: repeat ($urandom_range(1, 12)) push_key(REQ_TAKE, 8'($urandom));
        default: begin
          len = $urandom_range(0, 10);
          repeat (len)
            push_key(REQ_RECV, ($urandom_range(0, 4) == 0) ? special_char()
                                                            : 8'($urandom_range(32, 126)));
          case ($urandom_range(0, 3))
            0:       push_key(REQ_RECV, CH_CR);
            1:       push_key(REQ_RECV, slot_char(cfg_ccb, CCB_EOF));
            2:       push_key(REQ_RECV, special_char());
            default: push_key(REQ_RECV, CH_NL);
          endcase
        end
      endcase
    end
  endfunction

  // Fills the ring with one endless line, knocks on it while full, then
  // frees one slot so that a kill can walk the whole line back.
  function automatic void gen_fill();
    int unsigned room;
    logic [7:0]  c;
    room = (BUF_DEPTH - 1) - ((wr_ptr + BUF_DEPTH - rd_ptr) % BUF_DEPTH);
    repeat (room) begin
      do c = 8'($urandom);
      while (c == CH_NL || c == slot_char(cfg_ccb, CCB_EOF) ||
             c == slot_char(cfg_cca, CCA_ERASE) || c == slot_char(cfg_cca, CCA_KILL));
      push_key(REQ_RECV, c);
    end
    push_key(REQ_RECV, slot_char(cfg_cca, CCA_KILL));
    push_key(REQ_RECV, slot_char(cfg_cca, CCA_ERASE));
    push_key(REQ_RECV, 8'($urandom));
    push_key(REQ_RECV, CH_NL);
    push_key(REQ_TAKE, 8'($urandom));
    push_key(REQ_RECV, slot_char(cfg_cca, CCA_KILL));
    repeat (8) push_key(REQ_TAKE, 8'($urandom));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INPUT_FLAGS: cfg_iflags = val[4:0];
      REG_LOCAL_FLAGS: cfg_lflags = val[3:0];
      REG_CC_A:        cfg_cca    = val;
      REG_CC_B:        cfg_ccb    = val;
    endcase
  endtask

  task automatic set_config(logic [4:0] iflags, logic [3:0] lflags,
                            logic [31:0] cca, logic [31:0] ccb);
    write_reg(REG_INPUT_FLAGS, 32'(iflags));
    write_reg(REG_LOCAL_FLAGS, 32'(lflags));
    write_reg(REG_CC_A, cca);
    write_reg(REG_CC_B, ccb);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (keystroke_q.size() != 0 || awaited_res.size() != 0 || start);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : key_driver
    logic fire;
    if (!rst_n) begin
      start       <= 1'b0;
      in_req_type <= REQ_RECV;
      in_char     <= 8'd0;
      gap_left    = 0;
      burst_left  = 1;
    end else begin
      fire = start && !busy;
      if (fire) begin
        awaited_res.push_back(ldisc_step(in_req_type, in_char));
        keystroke_q.delete(0);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      // A beat that busy holds off stays on the bus untouched.
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (keystroke_q.size() > 0 &&
                     (!keystroke_q[0].hold || awaited_res.size() == 0)) begin
          start       <= 1'b1;
          in_req_type <= keystroke_q[0].req;
          in_char     <= keystroke_q[0].ch;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid) begin
      if (awaited_res.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
      end else begin
        want = awaited_res.pop_front();
        check_field("accepted", want.accepted, out_accepted);
        check_field("read_char", want.read_char, out_read_char);
        check_field("echo_count", want.echo_count, out_echo_count);
        check_field("echo_first", want.echo_first, out_echo_first);
        check_field("echo_second", want.echo_second, out_echo_second);
        check_field("rubout_count", want.rubout_count, out_rubout_count);
        check_field("signal_code", want.signal_code, out_signal_code);
        check_field("output_stopped", want.output_stopped, out_output_stopped);
        check_field("write_kick", want.write_kick, out_write_kick);
        check_field("line_count", want.line_count, out_line_count);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass under the reset settings.
    push_key(REQ_TAKE, 8'hA5);
    push_key(REQ_RECV, slot_char(RST_CC_A, CCA_ERASE));
    push_key(REQ_RECV, "a");
    push_key(REQ_RECV, 8'h00);
    push_key(REQ_RECV, 8'hFF);
    push_key(REQ_RECV, slot_char(RST_CC_A, CCA_ERASE));
    push_key(REQ_RECV, slot_char(RST_CC_A, CCA_KILL));
    push_key(REQ_RECV, "Q");
    push_key(REQ_RECV, CH_CR);
    push_key(REQ_RECV, slot_char(RST_CC_A, CCA_ERASE));
    push_key(REQ_RECV, slot_char(RST_CC_B, CCB_EOF));
    push_key(REQ_RECV, slot_char(RST_CC_A, CCA_INTR));
    push_key(REQ_RECV, slot_char(RST_CC_A, CCA_QUIT));
    push_key(REQ_RECV, slot_char(RST_CC_B, CCB_SUSP));
    push_key(REQ_RECV, slot_char(RST_CC_B, CCB_STOP));
    push_key(REQ_RECV, "~");
    push_key(REQ_RECV, slot_char(RST_CC_B, CCB_START));
    push_key(REQ_RECV, CH_SPACE);
    push_key(REQ_RECV, 8'h1F);
    push_key(REQ_RECV, 8'h80);
    repeat (5) push_key(REQ_TAKE, 8'h5A);
    wait_idle();

    set_config(5'h1F, 4'hF, RST_CC_A, RST_CC_B);
    gen_random(15);
    wait_idle();
    set_config(5'(1 << IF_IGNCR | 1 << IF_FOLD), 4'hF, rand_cc(), rand_cc());
    gen_random(15);
    wait_idle();
    set_config(5'(1 << IF_NLCR | 1 << IF_XON), 4'h0, 32'd0, 32'd0);
    gen_random(15);
    wait_idle();
    set_config(5'h00, 4'(1 << LF_CANON | 1 << LF_ECHO | 1 << LF_ECHOC), RST_CC_A, RST_CC_B);
    gen_fill();
    wait_idle();
    set_config(5'($urandom), 4'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    gen_random(15);
    wait_idle();
    set_config(5'($urandom), 4'($urandom), rand_cc(), rand_cc());
    gen_random(15);
    wait_idle();
    set_config(RST_INPUT_FLAGS, 4'(1 << LF_CANON | 1 << LF_SIG | 1 << LF_ECHO),
               RST_CC_A, RST_CC_B);
    gen_random(15);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
